[design/dpbp_pkg.sv]
// ---------------------------------------------------------------------------
// dpbp_pkg: shared types and constants of the depth pixel back-projection core
// Field widths, register indexes, opcodes and pose store types.
// ---------------------------------------------------------------------------
package dpbp_pkg;

  // Beat field widths
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned RGB_W      = 3 * COLOR_W;
  localparam int unsigned CIDX_W     = 4;
  localparam int unsigned CVAL_W     = 32;
  localparam int unsigned WORLD_W    = 32;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 120;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IFOC_W     = 24;
  localparam int unsigned PP_W       = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_FOCAL_X  = 3'd0,
    REG_INV_FOCAL_Y  = 3'd1,
    REG_PRINCIPAL_X  = 3'd2,
    REG_PRINCIPAL_Y  = 3'd3,
    REG_DEPTH_MIN    = 3'd4,
    REG_DEPTH_MAX    = 3'd5
  } cfg_reg_e;

  localparam logic [IFOC_W-1:0]  RST_INV_FOCAL_X = 24'd32768;
  localparam logic [IFOC_W-1:0]  RST_INV_FOCAL_Y = 24'd32768;
  localparam logic [PP_W-1:0]    RST_PRINCIPAL_X = 16'd5120;
  localparam logic [PP_W-1:0]    RST_PRINCIPAL_Y = 16'd3840;
  localparam logic [DEPTH_W-1:0] RST_DEPTH_MIN   = 16'd10;
  localparam logic [DEPTH_W-1:0] RST_DEPTH_MAX   = 16'd10000;

  // Beat kind carried in tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_POSE  = 1'b1;

  // Fixed-point layout
  localparam int unsigned ROT_Q     = 29;
  localparam int unsigned CAM_SHIFT = 28;
  localparam int unsigned MOD_W     = 4;

  // Pose store: rotation row-major in entries 0..8, translation in 9..11
  localparam int unsigned POSE_ENTRIES = 12;
  localparam int unsigned POSE_T_BASE  = 9;
  localparam logic signed [CVAL_W-1:0] POSE_ONE = 32'sh2000_0000;

  typedef logic signed [CVAL_W-1:0] pose_arr_t [POSE_ENTRIES];

  typedef struct packed {
    logic              en;
    logic [CIDX_W-1:0] idx;
    logic [CVAL_W-1:0] val;
  } pose_wr_t;

endpackage

[design/dpbp_pose_regs.sv]
// ---------------------------------------------------------------------------
// dpbp_pose_regs: camera-to-world pose store
// Twelve 32-bit entries, identity rotation and zero translation at reset.
// Writes to entries beyond the last are dropped.
// ---------------------------------------------------------------------------
module dpbp_pose_regs
  import dpbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pose_wr_t  wr_i,
  output pose_arr_t pose_o
);

  pose_arr_t pose_d;
  pose_arr_t pose_q;

  // Decode the write index
  always_comb begin
    for (int k = 0; k < POSE_ENTRIES; k++) begin
      pose_d[k] = pose_q[k];
      if (wr_i.en && (wr_i.idx == CIDX_W'(k))) begin
        pose_d[k] = $signed(wr_i.val);
      end
    end
  end

  // Hold entries, restore identity on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < POSE_ENTRIES; k++) begin
        pose_q[k] <= ((k == 0) || (k == 4) || (k == 8)) ? POSE_ONE : '0;
      end
    end else begin
      pose_q <= pose_d;
    end
  end

  assign pose_o = pose_q;

endmodule

[design/depth_pixel_backprojection_core.sv]
// ---------------------------------------------------------------------------
// depth_pixel_backprojection_core: depth pixels to colored world points
// A pixel beat passes stages 1 to 6 and the output register to the master
// side. Throughput: one beat per cycle, set by the 7-stage pipeline with
// per-stage enables; a stall on the master side fills bubbles before it
// holds the slave side. Pose loads travel the pipeline and write the pose
// store in order with pixels. Reset clears all valid bits, restores the
// register defaults and loads an identity pose.
// ---------------------------------------------------------------------------
module depth_pixel_backprojection_core
  import dpbp_pkg::*;
#(
  parameter int unsigned STRIDE     = 3,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // column, row, depth_mm, red_in, green_in, blue_in, coeff_index, coeff_value, pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                  s_axis_tuser,
  // Master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // world_x_mm, world_y_mm, world_z_mm, red_out, green_out, blue_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Stride remainder table: entry {r, nibble} gives (16*r + nibble) mod STRIDE
  typedef logic [MOD_W-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = MOD_W'(i % STRIDE);
    end
    return t;
  endfunction

  localparam mod_tab_t ModTab = build_mod_tab();

  localparam logic [COORD_W-1:0] CoordMask =
    (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);
  localparam logic [DEPTH_W-1:0] DepthMask =
    (DEPTH_BITS >= DEPTH_W) ? {DEPTH_W{1'b1}} : DEPTH_W'((1 << DEPTH_BITS) - 1);

  localparam logic signed [59:0] CamRound = 60'sd1 <<< (CAM_SHIFT - 1);
  localparam logic signed [65:0] AccRound = 66'sd1 <<< (ROT_Q - 1);
  localparam logic signed [37:0] WorldMax = 38'sd2147483647;
  localparam logic signed [37:0] WorldMin = -38'sd2147483648;

  // Stage payloads
  typedef struct {
    logic                     load;
    logic [CIDX_W-1:0]        cidx;
    logic [CVAL_W-1:0]        cval;
    logic signed [17:0]       dx;
    logic signed [17:0]       dy;
    logic [DEPTH_W-1:0]       d;
    logic                     rng;
    logic [MOD_W-1:0]         rmx;
    logic [MOD_W-1:0]         rmy;
    logic [7:0]               clo;
    logic [7:0]               rlo;
    logic [RGB_W-1:0]         rgb;
  } s1_t;

  typedef struct {
    logic                     load;
    logic [CIDX_W-1:0]        cidx;
    logic [CVAL_W-1:0]        cval;
    logic signed [34:0]       dxd;
    logic signed [34:0]       dyd;
    logic [DEPTH_W-1:0]       d;
    logic                     rng;
    logic [MOD_W-1:0]         rmx;
    logic [MOD_W-1:0]         rmy;
    logic [3:0]               cn;
    logic [3:0]               rn;
    logic [RGB_W-1:0]         rgb;
  } s2_t;

  typedef struct {
    logic                     load;
    logic [CIDX_W-1:0]        cidx;
    logic [CVAL_W-1:0]        cval;
    logic signed [59:0]       pxv;
    logic signed [59:0]       pyv;
    logic [DEPTH_W-1:0]       d;
    logic                     pix;
    logic [RGB_W-1:0]         rgb;
  } s3_t;

  typedef struct {
    logic                     load;
    logic [CIDX_W-1:0]        cidx;
    logic [CVAL_W-1:0]        cval;
    logic signed [31:0]       camx;
    logic signed [31:0]       camy;
    logic [DEPTH_W-1:0]       d;
    logic                     pix;
    logic [RGB_W-1:0]         rgb;
  } s4_t;

  typedef struct {
    logic                     pix;
    logic signed [63:0]       prod [9];
    logic signed [CVAL_W-1:0] t [3];
    logic [RGB_W-1:0]         rgb;
  } s5_t;

  typedef struct {
    logic                     pix;
    logic signed [65:0]       acc [3];
    logic signed [CVAL_W-1:0] t [3];
    logic [RGB_W-1:0]         rgb;
  } s6_t;

  typedef struct {
    logic [WORLD_W-1:0]       w [3];
    logic [RGB_W-1:0]         rgb;
  } out_t;

  // Configuration registers
  logic [IFOC_W-1:0]  ifx_d, ifx_q, ify_d, ify_q;
  logic [PP_W-1:0]    px_d, px_q, py_d, py_q;
  logic [DEPTH_W-1:0] dmin_d, dmin_q, dmax_d, dmax_q;

  // Pipeline
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, out_vld_q;
  logic en1, en2, en3, en4, en5, en6, en_out;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  s5_t  s5_d, s5_q;
  s6_t  s6_d, s6_q;
  out_t out_d, out_q;

  pose_wr_t  pose_wr;
  pose_arr_t pose;

  logic [COORD_W-1:0]  col_m, row_m;
  logic [DEPTH_W-1:0]  d_m;
  logic signed [59:0]  camx_sum, camy_sum;
  logic signed [37:0]  world [3];

  // Decode configuration writes
  always_comb begin
    ifx_d  = ifx_q;
    ify_d  = ify_q;
    px_d   = px_q;
    py_d   = py_q;
    dmin_d = dmin_q;
    dmax_d = dmax_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INV_FOCAL_X: ifx_d  = cfg_data_i;
        REG_INV_FOCAL_Y: ify_d  = cfg_data_i;
        REG_PRINCIPAL_X: px_d   = cfg_data_i[PP_W-1:0];
        REG_PRINCIPAL_Y: py_d   = cfg_data_i[PP_W-1:0];
        REG_DEPTH_MIN:   dmin_d = cfg_data_i[DEPTH_W-1:0];
        REG_DEPTH_MAX:   dmax_d = cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ifx_q  <= RST_INV_FOCAL_X;
      ify_q  <= RST_INV_FOCAL_Y;
      px_q   <= RST_PRINCIPAL_X;
      py_q   <= RST_PRINCIPAL_Y;
      dmin_q <= RST_DEPTH_MIN;
      dmax_q <= RST_DEPTH_MAX;
    end else begin
      ifx_q  <= ifx_d;
      ify_q  <= ify_d;
      px_q   <= px_d;
      py_q   <= py_d;
      dmin_q <= dmin_d;
      dmax_q <= dmax_d;
    end
  end

  // Stage enables: a stage loads when empty or when its content moves on
  assign en_out = !out_vld_q || m_axis_tready;
  assign en6    = !vld6_q || en_out;
  assign en5    = !vld5_q || en6;
  assign en4    = !vld4_q || en5;
  assign en3    = !vld3_q || en4;
  assign en2    = !vld2_q || en3;
  assign en1    = !vld1_q || en2;
  assign s_axis_tready = en1;

  // Stage 1: unpack, mask, offset from principal point, depth window, first remainder digit
  always_comb begin
    col_m = s_axis_tdata[11:0] & CoordMask;
    row_m = s_axis_tdata[23:12] & CoordMask;
    d_m   = s_axis_tdata[39:24] & DepthMask;

    s1_d.load = (s_axis_tuser == OP_POSE);
    s1_d.cidx = s_axis_tdata[67:64];
    s1_d.cval = s_axis_tdata[99:68];
    s1_d.dx   = $signed({2'b00, col_m, 4'b0000}) - $signed({2'b00, px_q});
    s1_d.dy   = $signed({2'b00, row_m, 4'b0000}) - $signed({2'b00, py_q});
    s1_d.d    = d_m;
    s1_d.rng  = (d_m >= dmin_q) && (d_m <= dmax_q);
    s1_d.rmx  = ModTab[{4'b0000, col_m[11:8]}];
    s1_d.rmy  = ModTab[{4'b0000, row_m[11:8]}];
    s1_d.clo  = col_m[7:0];
    s1_d.rlo  = row_m[7:0];
    s1_d.rgb  = s_axis_tdata[63:40];
  end

  // Stage 2: offset times depth, second remainder digit
  always_comb begin
    s2_d.load = s1_q.load;
    s2_d.cidx = s1_q.cidx;
    s2_d.cval = s1_q.cval;
    s2_d.dxd  = s1_q.dx * $signed({1'b0, s1_q.d});
    s2_d.dyd  = s1_q.dy * $signed({1'b0, s1_q.d});
    s2_d.d    = s1_q.d;
    s2_d.rng  = s1_q.rng;
    s2_d.rmx  = ModTab[{s1_q.rmx, s1_q.clo[7:4]}];
    s2_d.rmy  = ModTab[{s1_q.rmy, s1_q.rlo[7:4]}];
    s2_d.cn   = s1_q.clo[3:0];
    s2_d.rn   = s1_q.rlo[3:0];
    s2_d.rgb  = s1_q.rgb;
  end

  // Stage 3: scale by inverse focal length, decide whether the pixel is kept
  always_comb begin
    s3_d.load = s2_q.load;
    s3_d.cidx = s2_q.cidx;
    s3_d.cval = s2_q.cval;
    s3_d.pxv  = s2_q.dxd * $signed({1'b0, ifx_q});
    s3_d.pyv  = s2_q.dyd * $signed({1'b0, ify_q});
    s3_d.d    = s2_q.d;
    s3_d.pix  = !s2_q.load && s2_q.rng
                && (ModTab[{s2_q.rmx, s2_q.cn}] == '0)
                && (ModTab[{s2_q.rmy, s2_q.rn}] == '0);
    s3_d.rgb  = s2_q.rgb;
  end

  // Stage 4: round to camera millimetres
  always_comb begin
    camx_sum  = s3_q.pxv + CamRound;
    camy_sum  = s3_q.pyv + CamRound;
    s4_d.load = s3_q.load;
    s4_d.cidx = s3_q.cidx;
    s4_d.cval = s3_q.cval;
    s4_d.camx = $signed(camx_sum[59:CAM_SHIFT]);
    s4_d.camy = $signed(camy_sum[59:CAM_SHIFT]);
    s4_d.d    = s3_q.d;
    s4_d.pix  = s3_q.pix;
    s4_d.rgb  = s3_q.rgb;
  end

  // Pose loads write the store as they leave stage 4, in order with pixels
  assign pose_wr.en  = vld4_q && s4_q.load && en5;
  assign pose_wr.idx = s4_q.cidx;
  assign pose_wr.val = s4_q.cval;

  dpbp_pose_regs u_pose (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (pose_wr),
    .pose_o (pose)
  );

  // Stage 5: rotation products, pick up translation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_d.prod[i*3 + 0] = pose[i*3 + 0] * s4_q.camx;
      s5_d.prod[i*3 + 1] = pose[i*3 + 1] * s4_q.camy;
      s5_d.prod[i*3 + 2] = pose[i*3 + 2] * $signed({1'b0, s4_q.d});
      s5_d.t[i]          = pose[POSE_T_BASE + i];
    end
    s5_d.pix = s4_q.pix;
    s5_d.rgb = s4_q.rgb;
  end

  // Stage 6: sum each row with the rounding constant
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_d.acc[i] = 66'(s5_q.prod[i*3 + 0]) + 66'(s5_q.prod[i*3 + 1])
                    + 66'(s5_q.prod[i*3 + 2]) + AccRound;
      s6_d.t[i]   = s5_q.t[i];
    end
    s6_d.pix = s5_q.pix;
    s6_d.rgb = s5_q.rgb;
  end

  // Output stage: drop the fraction, add translation, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      world[i] = 38'($signed(s6_q.acc[i][65:ROT_Q])) + 38'(s6_q.t[i]);
      if (world[i] > WorldMax) begin
        out_d.w[i] = WorldMax[WORLD_W-1:0];
      end else if (world[i] < WorldMin) begin
        out_d.w[i] = WorldMin[WORLD_W-1:0];
      end else begin
        out_d.w[i] = world[i][WORLD_W-1:0];
      end
    end
    out_d.rgb = s6_q.rgb;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      vld6_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1)    vld1_q    <= s_axis_tvalid;
      if (en2)    vld2_q    <= vld1_q;
      if (en3)    vld3_q    <= vld2_q;
      if (en4)    vld4_q    <= vld3_q;
      if (en5)    vld5_q    <= vld4_q;
      if (en6)    vld6_q    <= vld5_q;
      if (en_out) out_vld_q <= vld6_q && s6_q.pix;
    end
  end

  // Advance payloads
  always_ff @(posedge clk_i) begin
    if (en1)    s1_q  <= s1_d;
    if (en2)    s2_q  <= s2_d;
    if (en3)    s3_q  <= s3_d;
    if (en4)    s4_q  <= s4_d;
    if (en5)    s5_q  <= s5_d;
    if (en6)    s6_q  <= s6_d;
    if (en_out) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.rgb, out_q.w[2], out_q.w[1], out_q.w[0]};

  // An empty output register lets the whole pipeline take a beat
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready
  ) else $error("slave side not ready while output register is empty");

  // A result appears only from a kept pixel in the last stage
  a_result_from_kept_pixel: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld6_q && s6_q.pix)
  ) else $error("result appeared without a kept pixel in the last stage");

  // A full first stage that cannot move blocks the slave side
  a_hold_when_first_stage_stuck: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (vld1_q && !en2) |-> !s_axis_tready
  ) else $error("slave side ready while the first stage is stuck");

endmodule
